### hw/rtl/length_prefixed_packet_deframer_assert.svh
// Assertion macros for the length-prefixed packet deframer.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### hw/rtl/lppd_pkg.sv
// Shared types and constants of the length-prefixed packet deframer.
package lppd_pkg;

    localparam int unsigned COUNT_WIDTH = 16;

    localparam logic [3:0]  HDR_BYTES = 4'd12;
    localparam logic [15:0] HDR_LEN   = 16'd12;
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_BAD_LEN = 2'd2,
        EV_DUP     = 2'd3
    } t_event;

endpackage

### hw/rtl/lppd_if.sv
// Request channels of the deframer: received bytes in, events out.
interface lppd_byte_if import lppd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lppd_evt_if import lppd_pkg::*; ();
    logic        valid;
    logic        ready;
    t_event      event_res;
    logic [7:0]  data_byte;
    logic [31:0] protocol_id;
    logic [31:0] seq_num;
    logic [15:0] payload_length;
    logic        last_of_packet;

    modport source (output valid, output event_res, output data_byte, output protocol_id,
                    output seq_num, output payload_length, output last_of_packet,
                    input ready);
    modport sink   (input valid, input event_res, input data_byte, input protocol_id,
                    input seq_num, input payload_length, input last_of_packet,
                    output ready);
endinterface

### hw/rtl/length_prefixed_packet_deframer.sv
// Top level: length-prefixed packet deframer with rejection of duplicate or older packet numbers.
//
//  channel   dir  payload                                           
//  i_rx      in   rx_byte                                           
//  o_evt     out  event_res data_byte protocol_id seq_num           
//                 payload_length last_of_packet                      
//  cfg       in   i_cfg_we / i_cfg_wdata = max_frame_length          
//
// One byte per cycle while o_evt is not stalled; a byte's parse step and any result land in the
// output register in the cycle it is accepted, so a result is visible in the cycle after its byte.
// The path is set by the 32-bit packet number compare on the last header byte.
// Synchronous active-low reset clears the header index, duplicate flag, last number and output valid.
// i_rx stalls only while o_evt holds a result that is not taken.
`include "length_prefixed_packet_deframer_assert.svh"

module length_prefixed_packet_deframer import lppd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata,
    lppd_byte_if.sink       i_rx,
    lppd_evt_if.source      o_evt
);

    logic [15:0]            r_max_len;
    logic [3:0]             r_hdr_idx,  n_hdr_idx;
    logic [23:0]            r_len,      n_len;
    logic [31:0]            r_num,      n_num;
    logic [31:0]            r_proto,    n_proto;
    logic [15:0]            r_plen,     n_plen;
    logic [COUNT_WIDTH-1:0] r_left,     n_left;
    logic [31:0]            r_last_num, n_last_num;
    logic                   r_dup,      n_dup;

    logic                   r_out_valid;
    t_event                 r_ev,       n_ev;
    logic [7:0]             r_data,     n_data;
    logic [31:0]            r_out_proto, n_out_proto;
    logic [31:0]            r_out_num,  n_out_num;
    logic [15:0]            r_out_plen, n_out_plen;
    logic                   r_out_last, n_out_last;
    logic                   n_res;

    logic                   acc;
    logic [7:0]             b;
    logic [15:0]            len16;
    logic [31:0]            proto_full;
    logic [COUNT_WIDTH-1:0] left_m1;
    logic                   bad_len;

    assign i_rx.ready = !r_out_valid || o_evt.ready;
    assign acc        = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign len16      = r_len[15:0];

    always_comb begin
        n_hdr_idx   = r_hdr_idx;
        n_len       = r_len;
        n_num       = r_num;
        n_proto     = r_proto;
        n_plen      = r_plen;
        n_left      = r_left;
        n_last_num  = r_last_num;
        n_dup       = r_dup;
        n_res       = 1'b0;
        n_ev        = EV_PAYLOAD;
        n_data      = 8'd0;
        n_out_proto = 32'd0;
        n_out_num   = 32'd0;
        n_out_plen  = 16'd0;
        n_out_last  = 1'b0;
        proto_full  = {b, r_proto[31:8]};
        left_m1     = r_left - COUNT_WIDTH'(1);
        bad_len     = (b != 8'd0) || (r_len[23:16] != 8'd0) || (len16 < HDR_LEN)
                      || (len16 > r_max_len);

        if (r_hdr_idx != HDR_BYTES) begin
            n_hdr_idx = r_hdr_idx + 4'd1;
            unique case (r_hdr_idx[3:2])
                2'd0: begin
                    // bytes shift in from the top; on byte 3 the length is checked and bytes 2 and 3 must be zero
                    n_len = {b, r_len[23:8]};
                    if (r_hdr_idx[1:0] == 2'd3) begin
                        if (bad_len) begin
                            n_hdr_idx = 4'd0;
                            n_res     = 1'b1;
                            n_ev      = EV_BAD_LEN;
                        end
                        n_plen = len16 - HDR_LEN;
                    end
                end
                2'd1: begin
                    n_num = {b, r_num[31:8]};
                end
                default: begin
                    n_proto = proto_full;
                    if (r_hdr_idx[1:0] == 2'd3) begin
                        n_left = COUNT_WIDTH'(r_plen);
                        n_dup  = (r_num <= r_last_num);
                        if (n_left == '0) begin
                            n_hdr_idx = 4'd0;
                        end
                        n_out_proto = proto_full;
                        n_out_num   = r_num;
                        n_out_plen  = r_plen;
                        if (n_dup) begin
                            n_res = 1'b1;
                            n_ev  = EV_DUP;
                        end else begin
                            n_last_num = r_num;
                            if (n_left == '0) begin
                                n_res      = 1'b1;
                                n_ev       = EV_EMPTY;
                                n_out_last = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end else begin
            n_left = left_m1;
            if (left_m1 == '0) begin
                n_hdr_idx = 4'd0;
            end
            if (!r_dup) begin
                n_res       = 1'b1;
                n_ev        = EV_PAYLOAD;
                n_data      = b;
                n_out_proto = r_proto;
                n_out_num   = r_num;
                n_out_plen  = r_plen;
                n_out_last  = (left_m1 == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_hdr_idx   <= 4'd0;
            r_last_num  <= 32'd0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (acc) begin
                r_hdr_idx  <= n_hdr_idx;
                r_last_num <= n_last_num;
                r_dup      <= n_dup;
            end
            if (acc && n_res) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_len   <= n_len;
            r_num   <= n_num;
            r_proto <= n_proto;
            r_plen  <= n_plen;
            r_left  <= n_left;
        end
        if (acc && n_res) begin
            r_ev        <= n_ev;
            r_data      <= n_data;
            r_out_proto <= n_out_proto;
            r_out_num   <= n_out_num;
            r_out_plen  <= n_out_plen;
            r_out_last  <= n_out_last;
        end
    end

    assign o_evt.valid          = r_out_valid;
    assign o_evt.event_res      = r_ev;
    assign o_evt.data_byte      = r_data;
    assign o_evt.protocol_id    = r_out_proto;
    assign o_evt.seq_num        = r_out_num;
    assign o_evt.payload_length = r_out_plen;
    assign o_evt.last_of_packet = r_out_last;

    `LPPD_ASSERT_NOW(a_hdr_idx_range, i_clk, i_rst_n, 1'b1, r_hdr_idx <= HDR_BYTES)
    `LPPD_ASSERT_NOW(a_bad_len_clean, i_clk, i_rst_n, r_out_valid && r_ev == EV_BAD_LEN,
        r_out_proto == 32'd0 && r_out_num == 32'd0 && !r_out_last)
    `LPPD_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, r_out_valid && r_ev == EV_EMPTY,
        r_out_last && r_out_plen == 16'd0)
    `LPPD_ASSERT_NEXT(a_payload_end, i_clk, i_rst_n,
        acc && r_hdr_idx == HDR_BYTES && r_left == COUNT_WIDTH'(1), r_hdr_idx == 4'd0)

endmodule
